>>> rtl/trc_pkg.sv
// ----------------------------------------------------------------------------
// trc_pkg : shared types and constants for the temporal reachability closure
// Sequencer states, the table entry word and default sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package trc_pkg;

  localparam int unsigned DEFAULT_MAX_NODES = 64;
  localparam int unsigned NODE_W            = 6;
  localparam int unsigned TIME_W            = 32;
  localparam logic [TIME_W-1:0] UNREACHED   = '1;

  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // one word of the distance table
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] span;
  } trc_entry_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_ISSUE,
    ST_RD_DATA,
    ST_E_CHK,
    ST_E_DEC,
    ST_A_DST_RD,
    ST_A_DST_WR,
    ST_A_SRC_RD,
    ST_DELTA,
    ST_WALK,
    ST_FINISH
  } trc_state_e;

endpackage : trc_pkg

`default_nettype wire

>>> rtl/trc_entry_ram.sv
// ----------------------------------------------------------------------------
// trc_entry_ram : distance table storage
// One write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module trc_entry_ram #(
  parameter int unsigned AW = 12
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [AW-1:0]             waddr_i,
  input  wire trc_pkg::trc_entry_t wdata_i,
  input  wire [AW-1:0]             raddr_a_i,
  input  wire [AW-1:0]             raddr_b_i,
  output trc_pkg::trc_entry_t      rdata_a_o,
  output trc_pkg::trc_entry_t      rdata_b_o
);

  localparam int unsigned DEPTH = 1 << AW;

  trc_pkg::trc_entry_t mem [DEPTH];
  trc_pkg::trc_entry_t rdata_a_q;
  trc_pkg::trc_entry_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule : trc_entry_ram

`default_nettype wire

>>> rtl/temporal_reachability_closure.sv
// ----------------------------------------------------------------------------
// temporal_reachability_closure : temporal distance table over an edge stream
// Applies time-ordered directed edges to an N x N table of temporal distances
// and per-node arrival times; answers single-entry reads.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+------------------------------------
//  in      | in  | in_valid_i/in_stall_o | command, from_node, to_node, edge_time
//  out     | out | out_valid_o/out_stall_i | applied, found, distance
//
//  After reset a clearing pass sweeps all 2^(2*ceil(log2(MAX_NODES))) table
//  entries (4096 at 64 nodes); arrival times are set to unreached in its
//  first row. No input is taken during the pass.
//  An input is taken only in the idle state. A read passes an issue and a data
//  state, an edge a check and a decision state, an out-of-range item goes
//  straight to finish; an applied edge then updates arrival times and walks.
//  The merge walks the source row one column a cycle through the two read
//  ports of the table memory, with one adder shared by every step.
//  The result sits in an output register; a new transfer is taken while it
//  waits, and the block holds in its last step only if the previous result
//  is still stalled.
//
`default_nettype none

module temporal_reachability_closure #(
  parameter int unsigned MAX_NODES = trc_pkg::DEFAULT_MAX_NODES
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_stall_o,
  input  wire                         command_i,
  input  wire [trc_pkg::NODE_W-1:0]   from_node_i,
  input  wire [trc_pkg::NODE_W-1:0]   to_node_i,
  input  wire [trc_pkg::TIME_W-1:0]   edge_time_i,
  output logic                        out_valid_o,
  input  wire                         out_stall_i,
  output logic                        applied_o,
  output logic                        found_o,
  output logic [trc_pkg::TIME_W-1:0]  distance_o
);

  localparam int unsigned NW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned AW    = 2 * NW;
  localparam int unsigned ADEPTH = 1 << NW;
  localparam int unsigned TW    = trc_pkg::TIME_W;

  trc_pkg::trc_state_e state_q, state_d;

  // latched command
  logic          cmd_q;
  logic [NW-1:0] src_q, dst_q;
  logic [TW-1:0] time_q;
  logic          range_ok;

  // control
  logic [AW-1:0] clr_q, clr_d;
  logic [NW:0]   col_q, col_d;
  logic [NW-1:0] pcol_q, pcol_d;
  logic          pv_q, pv_d;
  logic          first_q, first_d;
  logic [TW-1:0] delta_q, delta_d;

  // result staging and output register
  logic          res_applied_q, res_applied_d;
  logic          res_found_q, res_found_d;
  logic [TW-1:0] res_dist_q, res_dist_d;
  logic          out_valid_q, out_valid_d;
  logic          out_load;

  // table memory ports
  logic                entry_we;
  logic [AW-1:0]       entry_waddr;
  trc_pkg::trc_entry_t entry_wdata;
  logic [AW-1:0]       entry_raddr_a, entry_raddr_b;
  trc_pkg::trc_entry_t entry_rdata_a, entry_rdata_b;

  // arrival time memory
  logic [TW-1:0] arr_mem [ADEPTH];
  logic [TW-1:0] arr_rdata_q;
  logic          arr_we;
  logic [NW-1:0] arr_waddr, arr_raddr;
  logic [TW-1:0] arr_wdata;

  // shared adder
  logic [TW-1:0] add_a, add_b, add_sum;
  logic          add_cin;

  logic in_xfer;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign range_ok = ({{(32-trc_pkg::NODE_W){1'b0}}, from_node_i} < 32'(MAX_NODES)) &&
                    ({{(32-trc_pkg::NODE_W){1'b0}}, to_node_i} < 32'(MAX_NODES));
  assign add_sum  = add_a + add_b + {{(TW-1){1'b0}}, add_cin};

  trc_entry_ram #(
    .AW (AW)
  ) u_entry_ram (
    .clk_i     (clk_i),
    .we_i      (entry_we),
    .waddr_i   (entry_waddr),
    .wdata_i   (entry_wdata),
    .raddr_a_i (entry_raddr_a),
    .raddr_b_i (entry_raddr_b),
    .rdata_a_o (entry_rdata_a),
    .rdata_b_o (entry_rdata_b)
  );

  always_ff @(posedge clk_i) begin
    if (arr_we) begin
      arr_mem[arr_waddr] <= arr_wdata;
    end
    arr_rdata_q <= arr_mem[arr_raddr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      trc_pkg::ST_CLEAR: begin
        if (clr_q == '1) state_d = trc_pkg::ST_IDLE;
      end
      trc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (!range_ok)                      state_d = trc_pkg::ST_FINISH;
          else if (command_i == trc_pkg::CMD_READ) state_d = trc_pkg::ST_RD_ISSUE;
          else                                state_d = trc_pkg::ST_E_CHK;
        end
      end
      trc_pkg::ST_RD_ISSUE: state_d = trc_pkg::ST_RD_DATA;
      trc_pkg::ST_RD_DATA:  state_d = trc_pkg::ST_FINISH;
      trc_pkg::ST_E_CHK:    state_d = trc_pkg::ST_E_DEC;
      trc_pkg::ST_E_DEC: begin
        if (first_q && entry_rdata_a.valid) state_d = trc_pkg::ST_FINISH;
        else                                state_d = trc_pkg::ST_A_DST_RD;
      end
      trc_pkg::ST_A_DST_RD: state_d = trc_pkg::ST_A_DST_WR;
      trc_pkg::ST_A_DST_WR: state_d = trc_pkg::ST_A_SRC_RD;
      trc_pkg::ST_A_SRC_RD: state_d = trc_pkg::ST_DELTA;
      trc_pkg::ST_DELTA:    state_d = trc_pkg::ST_WALK;
      trc_pkg::ST_WALK: begin
        if ((col_q == (NW+1)'(MAX_NODES)) && !pv_q) state_d = trc_pkg::ST_FINISH;
      end
      trc_pkg::ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) state_d = trc_pkg::ST_IDLE;
      end
      default: state_d = trc_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o    = 1'b1;
    clr_d         = clr_q;
    col_d         = col_q;
    pcol_d        = pcol_q;
    pv_d          = 1'b0;
    first_d       = first_q;
    delta_d       = delta_q;
    res_applied_d = res_applied_q;
    res_found_d   = res_found_q;
    res_dist_d    = res_dist_q;
    out_load      = 1'b0;

    entry_we      = 1'b0;
    entry_waddr   = {dst_q, src_q};
    entry_wdata   = '{valid: 1'b1, span: add_sum};
    entry_raddr_a = {src_q, dst_q};
    entry_raddr_b = {dst_q, col_q[NW-1:0]};

    arr_we    = 1'b0;
    arr_waddr = src_q;
    arr_wdata = add_sum;
    arr_raddr = dst_q;

    add_a   = time_q;
    add_b   = '0;
    add_cin = 1'b0;

    case (state_q)
      trc_pkg::ST_CLEAR: begin
        entry_we    = 1'b1;
        entry_waddr = clr_q;
        entry_wdata = '{valid: 1'b0, span: '0};
        if (clr_q[AW-1:NW] == '0) begin
          arr_we    = 1'b1;
          arr_waddr = clr_q[NW-1:0];
          arr_wdata = trc_pkg::UNREACHED;
        end
        clr_d = clr_q + 1'b1;
      end
      trc_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_xfer) begin
          res_applied_d = 1'b0;
          res_found_d   = 1'b0;
          res_dist_d    = '0;
        end
      end
      trc_pkg::ST_RD_ISSUE: begin
        entry_raddr_a = {dst_q, src_q};
      end
      trc_pkg::ST_RD_DATA: begin
        if (entry_rdata_a.valid) begin
          res_found_d = 1'b1;
          res_dist_d  = entry_rdata_a.span;
        end
      end
      trc_pkg::ST_E_CHK: begin
        entry_raddr_a = {src_q, dst_q};
      end
      trc_pkg::ST_E_DEC: begin
        // adder: edge time minus one
        add_b = '1;
        if (!(first_q && entry_rdata_a.valid)) begin
          res_applied_d = 1'b1;
          if (!first_q) begin
            first_d   = 1'b1;
            arr_we    = 1'b1;
            arr_waddr = src_q;
          end
        end
      end
      trc_pkg::ST_A_DST_RD: begin
        arr_raddr = dst_q;
      end
      trc_pkg::ST_A_DST_WR: begin
        if (arr_rdata_q == trc_pkg::UNREACHED) begin
          arr_we    = 1'b1;
          arr_waddr = dst_q;
          arr_wdata = time_q;
        end
      end
      trc_pkg::ST_A_SRC_RD: begin
        arr_raddr = src_q;
      end
      trc_pkg::ST_DELTA: begin
        // adder: edge time minus source arrival
        add_b       = ~arr_rdata_q;
        add_cin     = 1'b1;
        delta_d     = add_sum;
        entry_we    = 1'b1;
        entry_waddr = {dst_q, src_q};
        col_d       = '0;
      end
      trc_pkg::ST_WALK: begin
        entry_raddr_a = {src_q, col_q[NW-1:0]};
        entry_raddr_b = {dst_q, col_q[NW-1:0]};
        if (col_q != (NW+1)'(MAX_NODES)) begin
          pv_d   = 1'b1;
          pcol_d = col_q[NW-1:0];
          col_d  = col_q + 1'b1;
        end
        // adder: source entry plus delta
        add_a = entry_rdata_a.span;
        add_b = delta_q;
        if (pv_q && entry_rdata_a.valid && !entry_rdata_b.valid) begin
          entry_we    = 1'b1;
          entry_waddr = {dst_q, pcol_q};
        end
      end
      trc_pkg::ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) out_load = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= trc_pkg::ST_CLEAR;
      clr_q       <= '0;
      col_q       <= '0;
      pv_q        <= 1'b0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      col_q       <= col_d;
      pv_q        <= pv_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q  <= command_i;
      src_q  <= NW'(from_node_i);
      dst_q  <= NW'(to_node_i);
      time_q <= edge_time_i;
    end
    pcol_q        <= pcol_d;
    delta_q       <= delta_d;
    res_applied_q <= res_applied_d;
    res_found_q   <= res_found_d;
    res_dist_q    <= res_dist_d;
    if (out_load) begin
      applied_o  <= res_applied_q;
      found_o    <= res_found_q;
      distance_o <= res_dist_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // checks

  // a read never reports an applied edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(applied_o && found_o))
    else $error("applied and found both set");

  // merge writes come only from a pipelined column
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (entry_we && state_q == trc_pkg::ST_WALK) |-> pv_q)
    else $error("walk write without read data");

  // finishing always presents a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o)
    else $error("result lost at finish");

  // a latched read command never enters the edge walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == trc_pkg::ST_WALK) |-> (cmd_q == trc_pkg::CMD_EDGE))
    else $error("read command in edge walk");

  // column counter stays within the row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= (NW+1)'(MAX_NODES))
    else $error("column counter overrun");

endmodule : temporal_reachability_closure

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb : self-checking bench for temporal_reachability_closure
// Streams edge and read transfers through the valid/stall channels. A fixed
// opening table is followed by random traffic. Each output transfer is checked
// against the table's typed answer or else a cycle-free closure model that the
// bench keeps in step with the input transfers it has issued.
// ----------------------------------------------------------------------------

module tb;

  localparam int unsigned NODES      = trc_pkg::DEFAULT_MAX_NODES;
  localparam int unsigned SLOTS      = NODES * NODES;
  localparam int unsigned RANDOM_OPS = 1180;
  // idle cycles tolerated with no transfer on either side; the clearing pass
  // after reset is the longest legal quiet stretch
  localparam int unsigned QUIET_LIMIT = 5 * SLOTS;
  localparam int unsigned DRAIN       = 2 * NODES + 32;

  typedef struct packed {
    logic                       op;
    logic [trc_pkg::NODE_W-1:0] src;
    logic [trc_pkg::NODE_W-1:0] dst;
    logic [trc_pkg::TIME_W-1:0] stamp;
  } graph_op_t;

  typedef struct packed {
    logic                       applied;
    logic                       found;
    logic [trc_pkg::TIME_W-1:0] distance;
  } answer_t;

  // typed == 1: the answer column is the expectation in place of the predictor's answer
  typedef struct packed {
    graph_op_t op;
    logic      typed;
    answer_t   want;
  } stim_row_t;

  logic                       clk_i;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       command_i   = trc_pkg::CMD_EDGE;
  logic [trc_pkg::NODE_W-1:0] from_node_i = '0;
  logic [trc_pkg::NODE_W-1:0] to_node_i   = '0;
  logic [trc_pkg::TIME_W-1:0] edge_time_i = '0;
  logic                       out_stall_i = 1'b0;
  logic                       in_stall_o;
  logic                       out_valid_o;
  logic                       applied_o;
  logic                       found_o;
  logic [trc_pkg::TIME_W-1:0] distance_o;

  // closure model state; a slot index is {target row, source column}
  logic                       reach_valid [SLOTS] = '{default: 1'b0};
  logic [trc_pkg::TIME_W-1:0] reach_dist  [SLOTS] = '{default: '0};
  logic [trc_pkg::TIME_W-1:0] arrive_at   [NODES] = '{default: trc_pkg::UNREACHED};
  logic                       seen_first_edge = 1'b0;
  logic [2*trc_pkg::NODE_W-1:0] filled_slots [$];

  answer_t     pending_answers [$];
  logic [trc_pkg::TIME_W-1:0] stream_clock;
  logic        calm        = 1'b0;   // suppresses idling on both sides
  int unsigned fail_count  = 0;
  int unsigned quiet_count = 0;

  temporal_reachability_closure dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .from_node_i (from_node_i),
    .to_node_i   (to_node_i),
    .edge_time_i (edge_time_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .applied_o   (applied_o),
    .found_o     (found_o),
    .distance_o  (distance_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Opening table. Rows with typed answers are the ones that are obvious:
  // reads of an empty table, the first edge (always applied, delta of one),
  // and an edge skipped because the source row already holds the target.
  stim_row_t directed_rows [21] = '{
    '{'{trc_pkg::CMD_READ, 6'd0,  6'd0,  32'd0},         1'b1, '{1'b0, 1'b0, 32'd0}},
    '{'{trc_pkg::CMD_READ, 6'd63, 6'd63, 32'hFFFF_FFFE}, 1'b1, '{1'b0, 1'b0, 32'd0}},
    '{'{trc_pkg::CMD_EDGE, 6'd5,  6'd7,  32'd1000},      1'b1, '{1'b1, 1'b0, 32'd0}},
    '{'{trc_pkg::CMD_READ, 6'd5,  6'd7,  32'd0},         1'b1, '{1'b0, 1'b1, 32'd1}},
    '{'{trc_pkg::CMD_EDGE, 6'd7,  6'd5,  32'd1000},      1'b1, '{1'b0, 1'b0, 32'd0}},
    // self loop on an unreached node: delta comes out zero
    '{'{trc_pkg::CMD_EDGE, 6'd10, 6'd10, 32'd1010},      1'b0, '0},
    '{'{trc_pkg::CMD_READ, 6'd10, 6'd10, 32'd0},         1'b0, '0},
    // unreached source: wrapped delta
    '{'{trc_pkg::CMD_EDGE, 6'd20, 6'd21, 32'd1020},      1'b0, '0},
    '{'{trc_pkg::CMD_READ, 6'd20, 6'd21, 32'd0},         1'b0, '0},
    // merge of row 7 into row 9
    '{'{trc_pkg::CMD_EDGE, 6'd7,  6'd9,  32'd1030},      1'b0, '0},
    '{'{trc_pkg::CMD_READ, 6'd5,  6'd9,  32'd0},         1'b0, '0},
    '{'{trc_pkg::CMD_READ, 6'd7,  6'd9,  32'd0},         1'b0, '0},
    // node and time extremes
    '{'{trc_pkg::CMD_EDGE, 6'd0,  6'd63, 32'd0},         1'b0, '0},
    '{'{trc_pkg::CMD_EDGE, 6'd63, 6'd0,  32'hFFFF_FFFE}, 1'b0, '0},
    '{'{trc_pkg::CMD_READ, 6'd63, 6'd0,  32'd0},         1'b0, '0},
    '{'{trc_pkg::CMD_READ, 6'd0,  6'd63, 32'd0},         1'b0, '0},
    '{'{trc_pkg::CMD_EDGE, 6'd9,  6'd5,  32'd1040},      1'b0, '0},
    '{'{trc_pkg::CMD_EDGE, 6'd5,  6'd9,  32'd1050},      1'b0, '0},
    '{'{trc_pkg::CMD_EDGE, 6'd9,  6'd7,  32'd1060},      1'b0, '0},
    '{'{trc_pkg::CMD_READ, 6'd42, 6'd21, 32'd0},         1'b1, '{1'b0, 1'b0, 32'd0}},
    // read ignores the time field
    '{'{trc_pkg::CMD_READ, 6'd5,  6'd7,  32'hFFFF_FFFE}, 1'b0, '0}
  };

  // Advance the closure model by one input transfer; returns its answer.
  function automatic answer_t closure_step(input graph_op_t op);
    answer_t                    a;
    logic [trc_pkg::TIME_W-1:0] delta;
    int unsigned                col;
    a = '0;
    if (op.op == trc_pkg::CMD_READ) begin
      if (reach_valid[{op.dst, op.src}]) begin
        a.found    = 1'b1;
        a.distance = reach_dist[{op.dst, op.src}];
      end
      return a;
    end
    if (seen_first_edge && reach_valid[{op.src, op.dst}]) return a;
    if (!seen_first_edge) begin
      seen_first_edge = 1'b1;
      arrive_at[op.src] = op.stamp - 1'b1;
    end
    if (arrive_at[op.dst] == trc_pkg::UNREACHED) arrive_at[op.dst] = op.stamp;
    delta = op.stamp - arrive_at[op.src];
    if (!reach_valid[{op.dst, op.src}])
      filled_slots.insert(filled_slots.size(), {op.dst, op.src});
    reach_valid[{op.dst, op.src}] = 1'b1;
    reach_dist[{op.dst, op.src}]  = delta;
    // self loop: source and target rows coincide, nothing to copy
    for (col = 0; col < NODES; col++) begin
      if (reach_valid[{op.src, trc_pkg::NODE_W'(col)}] &&
          !reach_valid[{op.dst, trc_pkg::NODE_W'(col)}]) begin
        reach_valid[{op.dst, trc_pkg::NODE_W'(col)}] = 1'b1;
        reach_dist[{op.dst, trc_pkg::NODE_W'(col)}]  =
          reach_dist[{op.src, trc_pkg::NODE_W'(col)}] + delta;
        filled_slots.insert(filled_slots.size(), {op.dst, trc_pkg::NODE_W'(col)});
      end
    end
    a.applied = 1'b1;
    return a;
  endfunction

  // Random traffic: mostly time-ordered edges among a small set of busy
  // nodes (so chains and merges build up), reads aimed at filled slots, and
  // some noise with arbitrary nodes and out-of-order times.
  function automatic graph_op_t next_random_op();
    graph_op_t                    op;
    int unsigned                  pick;
    logic [2*trc_pkg::NODE_W-1:0] slot;
    pick     = $urandom_range(0, 99);
    op.op    = trc_pkg::CMD_READ;
    op.src   = trc_pkg::NODE_W'($urandom_range(0, NODES - 1));
    op.dst   = trc_pkg::NODE_W'($urandom_range(0, NODES - 1));
    op.stamp = $urandom_range(0, 32'hFFFF_FFFE);
    if (pick >= 10 && pick < 45) begin
      if (filled_slots.size() != 0) begin
        slot   = filled_slots[$urandom_range(0, filled_slots.size() - 1)];
        op.dst = slot[2*trc_pkg::NODE_W-1:trc_pkg::NODE_W];
        op.src = slot[trc_pkg::NODE_W-1:0];
      end
    end else if (pick >= 45) begin
      op.op = trc_pkg::CMD_EDGE;
      if ($urandom_range(0, 99) < 70)
        op.src = trc_pkg::NODE_W'($urandom_range(0, 11) * 5 + 3);
      if ($urandom_range(0, 99) < 70)
        op.dst = trc_pkg::NODE_W'($urandom_range(0, 11) * 5 + 3);
      if ($urandom_range(0, 99) < 94) begin
        stream_clock = stream_clock + $urandom_range(0, 40);
        if (stream_clock == trc_pkg::UNREACHED) stream_clock = '0;
        op.stamp = stream_clock;
      end
    end
    return op;
  endfunction

  // One input transfer: optional idle cycles, then hold until accepted.
  task automatic send_op(input graph_op_t op, input logic typed, input answer_t want);
    answer_t predicted;
    while (!calm && $urandom_range(0, 99) < 16) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= op.op;
    from_node_i <= op.src;
    to_node_i   <= op.dst;
    edge_time_i <= op.stamp;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predicted = closure_step(op);
    if (typed) predicted = want;
    pending_answers.insert(pending_answers.size(), predicted);
  endtask

  initial begin : stimulus
    int unsigned i;
    stream_clock = $urandom_range(2000, 32'hF000_0000);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    // the block stalls its input through the clearing pass
    foreach (directed_rows[r])
      send_op(directed_rows[r].op, directed_rows[r].typed, directed_rows[r].want);
    for (i = 0; i < RANDOM_OPS; i++) begin
      calm <= (i >= 400 && i < 600);
      // let the pipe run dry twice mid-run
      if (i == 250 || i == 850) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (pending_answers.size() != 0);
      end
      send_op(next_random_op(), 1'b0, '0);
    end
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_answers.size() != 0);
    repeat (DRAIN) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Output side: check each result transfer, randomize stall, and run the
  // watchdog on transfer activity of both channels.
  always @(posedge clk_i) begin : result_check
    answer_t want;
    if (out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result: applied %0d found %0d distance %0h",
               applied_o, found_o, distance_o);
        fail_count++;
      end else begin
        want = pending_answers.pop_front();
        if (applied_o !== want.applied) begin
          $error("applied: expected %0d, got %0d", want.applied, applied_o);
          fail_count++;
        end
        if (found_o !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found_o);
          fail_count++;
        end
        if (distance_o !== want.distance) begin
          $error("distance: expected %0h, got %0h", want.distance, distance_o);
          fail_count++;
        end
      end
    end
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
    end
    if (quiet_count >= QUIET_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
    out_stall_i <= !calm && ($urandom_range(0, 99) < 16);
  end

endmodule

>>> files.f
rtl/trc_pkg.sv
rtl/trc_entry_ram.sv
rtl/temporal_reachability_closure.sv
tb/tb.sv
